### rtl/q2e_pkg.sv
// ============================================================================
// q2e_pkg: shared types and constants for the quaternion to Euler converter
// Lane type of the CORDIC chain, angle table in Q20 radians, output limits.
// ============================================================================
package q2e_pkg;

    localparam int CORD_W  = 64;
    localparam int ANG_W   = 24;
    localparam int QN_W    = 30;
    localparam int TAB_LEN = 24;
    localparam int CONV_W  = 26;

    localparam logic signed [ANG_W-1:0]  HALF_PI_Q20     = 24'sd1647099;
    localparam logic signed [CONV_W-1:0] LIM_PI_Q13      = 26'sd25736;
    localparam logic signed [CONV_W-1:0] LIM_HALF_PI_Q13 = 26'sd12868;
    localparam logic signed [CONV_W-1:0] ROUND_Q13       = 26'sd64;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
        24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
        24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
        24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
        24'sd256,    24'sd128,    24'sd64,     24'sd32,
        24'sd16,     24'sd8,      24'sd4,      24'sd2,
        24'sd1,      24'sd0,      24'sd0,      24'sd0
    };

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        logic                     zf;
    } cord_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] yaw_x;
        logic signed [CORD_W-1:0] yaw_y;
        logic signed [CORD_W-1:0] roll_x;
        logic signed [CORD_W-1:0] roll_y;
        logic signed [CORD_W-1:0] pp_x;
        logic signed [CORD_W-1:0] pp_y;
        logic signed [CORD_W-1:0] pm_x;
        logic signed [CORD_W-1:0] pm_y;
        logic                     zq;
    } front_t;

    function automatic logic signed [ANG_W-1:0] atan_q20(input int idx);
        return ATAN_TAB[idx];
    endfunction

endpackage

### rtl/quaternion_to_euler.sv
// ============================================================================
// quaternion_to_euler: unit quaternion to yaw, pitch and roll
// Pipelined block scaling and CORDIC chains, one transaction per cycle unless stalled.
// ============================================================================
// Usage:
//   Input channel quat_valid/quat_ready carries one quaternion (w, x, y, z),
//   signed Q30. Output channel euler_valid/euler_ready carries yaw, pitch,
//   roll in radians, signed Q2.13 (pitch Q1.13), one result per input transaction.
//   A zero quaternion yields all three angles zero.
//   Throughput: one transaction per cycle while the skid entry is free.
//   Pipeline: five front stages, two CORDIC chains of CORDIC_STEPS+1 stages each,
//   one conversion stage and one output register.
//   The whole pipeline advances together; a two-entry output register and
//   skid buffer absorb a stalled receiver. quat_ready drops only once the
//   skid entry is occupied and returns in the cycle after the receiver takes
//   a result.
//   Reset clears all valid bits; the pipeline holds no results afterward.
// ============================================================================
module quaternion_to_euler #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               quat_valid,
    output logic               quat_ready,
    input  logic signed [31:0] quat_w,
    input  logic signed [31:0] quat_x,
    input  logic signed [31:0] quat_y,
    input  logic signed [31:0] quat_z,
    output logic               euler_valid,
    input  logic               euler_ready,
    output logic signed [15:0] yaw,
    output logic signed [14:0] pitch,
    output logic signed [15:0] roll
);
    import q2e_pkg::*;

    localparam int FRONT_LAT = 5;
    localparam int CHAIN_LAT = CORDIC_STEPS + 1;
    localparam int DEPTH     = FRONT_LAT + 2 * CHAIN_LAT + 1;

    logic                     en;
    logic [DEPTH-1:0]         vld_reg;
    front_t                   front;
    cord_t                    yaw_lane, roll_lane, pp_lane, pm_lane, th_lane;

    logic signed [ANG_W-1:0]  yaw_dly_reg [CHAIN_LAT];
    logic signed [ANG_W-1:0]  roll_dly_reg [CHAIN_LAT];
    logic [2*CHAIN_LAT-1:0]   zq_dly_reg;

    logic signed [CONV_W-1:0] ya, yr, ra, rr, pa, pr;
    logic signed [15:0]       yaw_next, roll_next;
    logic signed [14:0]       pitch_next;
    logic signed [15:0]       yaw_c_reg, roll_c_reg;
    logic signed [14:0]       pitch_c_reg;

    logic                     out_vld_reg, skid_vld_reg;
    logic signed [15:0]       yaw_o_reg, roll_o_reg, yaw_s_reg, roll_s_reg;
    logic signed [14:0]       pitch_o_reg, pitch_s_reg;
    logic                     up_vld;

    assign en         = !skid_vld_reg;
    assign quat_ready = en;

    q2e_front u_front (
        .clk       (clk),
        .en        (en),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .front_out (front)
    );

    q2e_cordic_chain #(.STEPS(CORDIC_STEPS)) u_yaw (
        .clk(clk), .en(en), .vec_x(front.yaw_x), .vec_y(front.yaw_y), .lane_out(yaw_lane)
    );

    q2e_cordic_chain #(.STEPS(CORDIC_STEPS)) u_roll (
        .clk(clk), .en(en), .vec_x(front.roll_x), .vec_y(front.roll_y),
        .lane_out(roll_lane)
    );

    q2e_cordic_chain #(.STEPS(CORDIC_STEPS)) u_pp (
        .clk(clk), .en(en), .vec_x(front.pp_x), .vec_y(front.pp_y), .lane_out(pp_lane)
    );

    q2e_cordic_chain #(.STEPS(CORDIC_STEPS)) u_pm (
        .clk(clk), .en(en), .vec_x(front.pm_x), .vec_y(front.pm_y), .lane_out(pm_lane)
    );

    q2e_cordic_chain #(.STEPS(CORDIC_STEPS)) u_th (
        .clk(clk), .en(en), .vec_x(pm_lane.x), .vec_y(pp_lane.x), .lane_out(th_lane)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], quat_valid && quat_ready};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_dly_reg[0]  <= yaw_lane.z;
            roll_dly_reg[0] <= roll_lane.z;
            for (int i = 1; i < CHAIN_LAT; i++)
            begin
                yaw_dly_reg[i]  <= yaw_dly_reg[i-1];
                roll_dly_reg[i] <= roll_dly_reg[i-1];
            end
            zq_dly_reg <= {zq_dly_reg[2*CHAIN_LAT-2:0], front.zq};
        end
    end

    always_comb
    begin
        ya = CONV_W'(yaw_dly_reg[CHAIN_LAT-1]) + ROUND_Q13;
        yr = ya >>> 7;
        ra = CONV_W'(roll_dly_reg[CHAIN_LAT-1]) + ROUND_Q13;
        rr = ra >>> 7;
        pa = (CONV_W'(th_lane.z) <<< 1) - CONV_W'(HALF_PI_Q20) + ROUND_Q13;
        pr = pa >>> 7;
        if (yr > LIM_PI_Q13)
        begin
            yr = LIM_PI_Q13;
        end
        else if (yr < -LIM_PI_Q13)
        begin
            yr = -LIM_PI_Q13;
        end
        if (rr > LIM_PI_Q13)
        begin
            rr = LIM_PI_Q13;
        end
        else if (rr < -LIM_PI_Q13)
        begin
            rr = -LIM_PI_Q13;
        end
        if (pr > LIM_HALF_PI_Q13)
        begin
            pr = LIM_HALF_PI_Q13;
        end
        else if (pr < -LIM_HALF_PI_Q13)
        begin
            pr = -LIM_HALF_PI_Q13;
        end
        if (zq_dly_reg[2*CHAIN_LAT-1])
        begin
            yaw_next   = '0;
            pitch_next = '0;
            roll_next  = '0;
        end
        else
        begin
            yaw_next   = yr[15:0];
            pitch_next = pr[14:0];
            roll_next  = rr[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_c_reg   <= yaw_next;
            pitch_c_reg <= pitch_next;
            roll_c_reg  <= roll_next;
        end
    end

    assign up_vld = en && vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || euler_ready)
        begin
            out_vld_reg  <= up_vld || skid_vld_reg;
            skid_vld_reg <= 1'b0;
        end
        else if (up_vld)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || euler_ready)
        begin
            if (skid_vld_reg)
            begin
                yaw_o_reg   <= yaw_s_reg;
                pitch_o_reg <= pitch_s_reg;
                roll_o_reg  <= roll_s_reg;
            end
            else
            begin
                yaw_o_reg   <= yaw_c_reg;
                pitch_o_reg <= pitch_c_reg;
                roll_o_reg  <= roll_c_reg;
            end
        end
        else if (up_vld)
        begin
            yaw_s_reg   <= yaw_c_reg;
            pitch_s_reg <= pitch_c_reg;
            roll_s_reg  <= roll_c_reg;
        end
    end

    assign euler_valid = out_vld_reg;
    assign yaw         = yaw_o_reg;
    assign pitch       = pitch_o_reg;
    assign roll        = roll_o_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry held without an output result");

    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !euler_ready && vld_reg[DEPTH-1] && !skid_vld_reg)
        |=> skid_vld_reg && !quat_ready)
        else $error("stalled result not captured in skid entry");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid |-> (pitch <= 15'sd12868) && (pitch >= -15'sd12868))
        else $error("pitch out of range");

    a_yaw_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid |-> (yaw <= 16'sd25736) && (yaw >= -16'sd25736)
            && (roll <= 16'sd25736) && (roll >= -16'sd25736))
        else $error("yaw or roll out of range");

endmodule

### rtl/q2e_cordic_cell.sv
// ============================================================================
// q2e_cordic_cell: one vectoring CORDIC iteration
// Rotates the lane toward the x axis by the angle of its step, registered; a lane flagged zero passes unchanged.
// ============================================================================
module q2e_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            en,
    input  q2e_pkg::cord_t  lane_in,
    output q2e_pkg::cord_t  lane_out
);
    import q2e_pkg::*;

    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;
    cord_t                    lane_next;
    cord_t                    lane_reg;

    always_comb
    begin
        xs = lane_in.x >>> STEP;
        ys = lane_in.y >>> STEP;
        lane_next = lane_in;
        if (!lane_in.zf)
        begin
            if (!lane_in.y[CORD_W-1])
            begin
                lane_next.x = lane_in.x + ys;
                lane_next.y = lane_in.y - xs;
                lane_next.z = lane_in.z + atan_q20(STEP);
            end
            else
            begin
                lane_next.x = lane_in.x - ys;
                lane_next.y = lane_in.y + xs;
                lane_next.z = lane_in.z - atan_q20(STEP);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

### rtl/q2e_cordic_chain.sv
// ============================================================================
// q2e_cordic_chain: vectoring CORDIC as a row of iteration cells
// Quadrant fold into the right half plane, then one cell per iteration.
// ============================================================================
module q2e_cordic_chain #(
    parameter int STEPS = 16
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [q2e_pkg::CORD_W-1:0]    vec_x,
    input  logic signed [q2e_pkg::CORD_W-1:0]    vec_y,
    output q2e_pkg::cord_t                       lane_out
);
    import q2e_pkg::*;

    cord_t pre_next;
    cord_t pre_reg;
    cord_t lane [STEPS+1];

    always_comb
    begin
        pre_next.x  = vec_x;
        pre_next.y  = vec_y;
        pre_next.z  = '0;
        pre_next.zf = (vec_x == '0) && (vec_y == '0);
        if (vec_x[CORD_W-1])
        begin
            if (!vec_y[CORD_W-1])
            begin
                pre_next.x = vec_y;
                pre_next.y = -vec_x;
                pre_next.z = HALF_PI_Q20;
            end
            else
            begin
                pre_next.x = -vec_y;
                pre_next.y = vec_x;
                pre_next.z = -HALF_PI_Q20;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg <= pre_next;
        end
    end

    assign lane[0] = pre_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        q2e_cordic_cell #(
            .STEP(i)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .lane_in  (lane[i]),
            .lane_out (lane[i+1])
        );
    end

    assign lane_out = lane[STEPS];

endmodule

### rtl/q2e_front.sv
// ============================================================================
// q2e_front: block scaling, products and sums ahead of the CORDIC chains
// Five register stages from the captured quaternion to the chain operands.
// ============================================================================
module q2e_front (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [31:0]       quat_w,
    input  logic signed [31:0]       quat_x,
    input  logic signed [31:0]       quat_y,
    input  logic signed [31:0]       quat_z,
    output q2e_pkg::front_t          front_out
);
    import q2e_pkg::*;

    logic signed [31:0]       q_in [4];
    logic [31:0]              mag_reg [4];
    logic [3:0]               neg_reg;

    logic [31:0]              orv;
    logic [4:0]               lead;
    logic [28:0]              smag [4];
    logic signed [QN_W-1:0]   c_next [4];
    logic signed [QN_W-1:0]   c_reg [4];
    logic                     zq2_reg;

    logic signed [2*QN_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [2*QN_W-1:0] wz_reg, xy_reg, wx_reg, yz_reg;
    logic signed [QN_W:0]     wpy_reg, xmz_reg, wmy_reg, xpz_reg;
    logic                     zq3_reg;

    logic signed [61:0]       a_reg, b_reg, c4_reg, d_reg, e_reg, f_reg;
    logic signed [QN_W:0]     wpy4_reg, xmz4_reg, wmy4_reg, xpz4_reg;
    logic                     zq4_reg;

    front_t                   out_reg;

    assign q_in[0] = quat_w;
    assign q_in[1] = quat_x;
    assign q_in[2] = quat_y;
    assign q_in[3] = quat_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                mag_reg[k] <= q_in[k][31] ? (~q_in[k] + 32'd1) : q_in[k];
                neg_reg[k] <= q_in[k][31];
            end
        end
    end

    always_comb
    begin
        orv  = mag_reg[0] | mag_reg[1] | mag_reg[2] | mag_reg[3];
        lead = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (orv[i])
            begin
                lead = 5'(i);
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            if (lead >= 5'd28)
            begin
                smag[k] = 29'(mag_reg[k] >> (lead - 5'd28));
            end
            else
            begin
                smag[k] = 29'(mag_reg[k] << (5'd28 - lead));
            end
            c_next[k] = neg_reg[k] ? -$signed({1'b0, smag[k]}) : $signed({1'b0, smag[k]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                c_reg[k] <= c_next[k];
            end
            zq2_reg <= (orv == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg  <= c_reg[0] * c_reg[0];
            xx_reg  <= c_reg[1] * c_reg[1];
            yy_reg  <= c_reg[2] * c_reg[2];
            zz_reg  <= c_reg[3] * c_reg[3];
            wz_reg  <= c_reg[0] * c_reg[3];
            xy_reg  <= c_reg[1] * c_reg[2];
            wx_reg  <= c_reg[0] * c_reg[1];
            yz_reg  <= c_reg[2] * c_reg[3];
            wpy_reg <= (QN_W+1)'(c_reg[0]) + (QN_W+1)'(c_reg[2]);
            xmz_reg <= (QN_W+1)'(c_reg[1]) - (QN_W+1)'(c_reg[3]);
            wmy_reg <= (QN_W+1)'(c_reg[0]) - (QN_W+1)'(c_reg[2]);
            xpz_reg <= (QN_W+1)'(c_reg[1]) + (QN_W+1)'(c_reg[3]);
            zq3_reg <= zq2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= 62'(ww_reg) + 62'(xx_reg);
            b_reg    <= 62'(yy_reg) + 62'(zz_reg);
            c4_reg   <= 62'(ww_reg) - 62'(xx_reg);
            d_reg    <= 62'(zz_reg) - 62'(yy_reg);
            e_reg    <= 62'(wz_reg) + 62'(xy_reg);
            f_reg    <= 62'(wx_reg) + 62'(yz_reg);
            wpy4_reg <= wpy_reg;
            xmz4_reg <= xmz_reg;
            wmy4_reg <= wmy_reg;
            xpz4_reg <= xpz_reg;
            zq4_reg  <= zq3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.yaw_x  <= CORD_W'(a_reg) - CORD_W'(b_reg);
            out_reg.yaw_y  <= CORD_W'(e_reg) <<< 1;
            out_reg.roll_x <= CORD_W'(c4_reg) + CORD_W'(d_reg);
            out_reg.roll_y <= CORD_W'(f_reg) <<< 1;
            out_reg.pp_x   <= CORD_W'(wpy4_reg);
            out_reg.pp_y   <= CORD_W'(xmz4_reg);
            out_reg.pm_x   <= CORD_W'(wmy4_reg);
            out_reg.pm_y   <= CORD_W'(xpz4_reg);
            out_reg.zq     <= zq4_reg;
        end
    end

    assign front_out = out_reg;

endmodule
